[src/vau_pkg.sv]
package vau_pkg;

    // Fixed-point format and derived pipeline depths.
    localparam int FRAC_BITS  = 16;
    localparam int DIV_BITS   = 32 + FRAC_BITS;
    localparam int SQRT_STEPS = 32;
    localparam int PIPE_DEPTH = 4 + SQRT_STEPS + DIV_BITS;

    localparam logic [32:0]         FIX_ONE = 33'd1 << FRAC_BITS;
    localparam logic [DIV_BITS-1:0] DQ_ONE  = DIV_BITS'(1);

    // Operation codes.
    localparam logic [3:0] CMD_ADD    = 4'd0;
    localparam logic [3:0] CMD_SUB    = 4'd1;
    localparam logic [3:0] CMD_SCALE  = 4'd2;
    localparam logic [3:0] CMD_DIVIDE = 4'd3;
    localparam logic [3:0] CMD_DOT    = 4'd4;
    localparam logic [3:0] CMD_CROSS  = 4'd5;
    localparam logic [3:0] CMD_LENGTH = 4'd6;
    localparam logic [3:0] CMD_DIST   = 4'd7;
    localparam logic [3:0] CMD_NORM   = 4'd8;
    localparam logic [3:0] CMD_EQUAL  = 4'd9;

    typedef logic signed [31:0] fix_t;

    // Per-item context carried along the pipeline.
    typedef struct packed {
        logic [3:0]  cmd;
        fix_t [2:0]  a;
        fix_t        s;
        fix_t [2:0]  v;
        fix_t        sc;
        logic        eq;
        logic        sat;
    } ctx_t;

    // What one lane hands to the merging stage.
    typedef struct packed {
        logic [32:0]        sum;
        logic [32:0]        dif;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic [63:0]        sq;
    } lane_res_t;

    // Saturate to 32 bits; the top bit of the result is the clip flag.
    function automatic logic [32:0] sat32(input logic signed [66:0] val);
        if (val > 67'sd2147483647) begin
            return {1'b1, 32'h7fff_ffff};
        end else if (val < -67'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, val[31:0]};
        end
    endfunction

endpackage

[src/vau_lane.sv]
module vau_lane (
    input  logic               aclk,
    input  logic               en,
    input  logic [3:0]         cmd,
    input  vau_pkg::fix_t      ai,
    input  vau_pkg::fix_t      bi,
    input  vau_pkg::fix_t      s,
    input  vau_pkg::fix_t      aj,
    input  vau_pkg::fix_t      bk,
    input  vau_pkg::fix_t      ak,
    input  vau_pkg::fix_t      bj,
    output vau_pkg::lane_res_t res
);

    logic [32:0] sum_next, dif_next, sum_reg, dif_reg, sum2_reg, dif2_reg;
    vau_pkg::fix_t m0a_next, m0b_next, m1a_next, m1b_next, q_next;
    vau_pkg::fix_t m0a_reg, m0b_reg, m1a_reg, m1b_reg, q_reg;
    logic signed [63:0] p0_next, p1_next, sq_next;
    logic signed [63:0] p0_reg, p1_reg, sq_reg;

    // Saturating sum and difference of this component.
    assign sum_next = vau_pkg::sat32(67'(ai) + 67'(bi));
    assign dif_next = vau_pkg::sat32(67'(ai) - 67'(bi));

    // Multiplier operands depend on the operation.
    always_comb begin
        m0a_next = ai;
        m0b_next = s;
        m1a_next = ak;
        m1b_next = bj;
        unique case (cmd)
            vau_pkg::CMD_DOT: begin
                m0b_next = bi;
            end
            vau_pkg::CMD_CROSS: begin
                m0a_next = aj;
                m0b_next = bk;
            end
            default: begin
            end
        endcase
        q_next = (cmd == vau_pkg::CMD_DIST) ? vau_pkg::fix_t'(dif_next[31:0]) : ai;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            dif_reg <= dif_next;
            m0a_reg <= m0a_next;
            m0b_reg <= m0b_next;
            m1a_reg <= m1a_next;
            m1b_reg <= m1b_next;
            q_reg   <= q_next;
        end
    end

    // Products of the second stage.
    assign p0_next = m0a_reg * m0b_reg;
    assign p1_next = m1a_reg * m1b_reg;
    assign sq_next = q_reg * q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum2_reg <= sum_reg;
            dif2_reg <= dif_reg;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            sq_reg   <= sq_next;
        end
    end

    assign res.sum = sum2_reg;
    assign res.dif = dif2_reg;
    assign res.p0  = p0_reg;
    assign res.p1  = p1_reg;
    assign res.sq  = sq_reg;

endmodule

[src/vau_merge.sv]
module vau_merge (
    input  logic               aclk,
    input  logic               en,
    input  vau_pkg::ctx_t      ctx_in,
    input  vau_pkg::lane_res_t lanes [3],
    output vau_pkg::ctx_t      ctx_out,
    output logic [63:0]        sumsq_out
);

    vau_pkg::ctx_t      ctx_next, ctx_reg;
    logic [63:0]        sumsq_next, sumsq_reg;
    logic signed [65:0] dot;
    logic signed [64:0] crs [3];
    logic [32:0]        t_sc [3];
    logic [32:0]        t_cr [3];
    logic [32:0]        t_dot;

    // Combine the lane results according to the operation.
    always_comb begin
        dot = $signed(lanes[0].p0) + $signed(lanes[1].p0) + $signed(lanes[2].p0);
        t_dot = vau_pkg::sat32(67'(dot >>> vau_pkg::FRAC_BITS));
        sumsq_next = lanes[0].sq + lanes[1].sq + lanes[2].sq;
        for (int i = 0; i < 3; i++) begin
            crs[i]  = $signed(lanes[i].p0) - $signed(lanes[i].p1);
            t_cr[i] = vau_pkg::sat32(67'(crs[i] >>> vau_pkg::FRAC_BITS));
            t_sc[i] = vau_pkg::sat32(67'($signed(lanes[i].p0) >>> vau_pkg::FRAC_BITS));
        end
        ctx_next     = ctx_in;
        ctx_next.v   = '0;
        ctx_next.sc  = '0;
        ctx_next.sat = 1'b0;
        unique case (ctx_in.cmd)
            vau_pkg::CMD_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    ctx_next.v[i] = lanes[i].sum[31:0];
                    ctx_next.sat  = ctx_next.sat | lanes[i].sum[32];
                end
            end
            vau_pkg::CMD_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    ctx_next.v[i] = lanes[i].dif[31:0];
                    ctx_next.sat  = ctx_next.sat | lanes[i].dif[32];
                end
            end
            vau_pkg::CMD_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    ctx_next.v[i] = t_sc[i][31:0];
                    ctx_next.sat  = ctx_next.sat | t_sc[i][32];
                end
            end
            vau_pkg::CMD_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    ctx_next.v[i] = t_cr[i][31:0];
                    ctx_next.sat  = ctx_next.sat | t_cr[i][32];
                end
            end
            vau_pkg::CMD_DOT: begin
                ctx_next.sc  = t_dot[31:0];
                ctx_next.sat = t_dot[32];
            end
            vau_pkg::CMD_DIST: begin
                ctx_next.sat = lanes[0].dif[32] | lanes[1].dif[32] | lanes[2].dif[32];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg   <= ctx_next;
            sumsq_reg <= sumsq_next;
        end
    end

    assign ctx_out   = ctx_reg;
    assign sumsq_out = sumsq_reg;

endmodule

[src/vau_sqrt.sv]
module vau_sqrt (
    input  logic          aclk,
    input  logic          en,
    input  vau_pkg::ctx_t ctx_in,
    input  logic [63:0]   n_in,
    output vau_pkg::ctx_t ctx_out,
    output logic [31:0]   root_out
);

    localparam int LAST = vau_pkg::SQRT_STEPS - 1;

    vau_pkg::ctx_t ctx_reg  [vau_pkg::SQRT_STEPS];
    logic [31:0]   root_reg [vau_pkg::SQRT_STEPS];
    logic [63:0]   rem_reg  [LAST];

    // One result bit per stage, most significant first.
    for (genvar j = 0; j < vau_pkg::SQRT_STEPS; j++) begin : g_step
        localparam int K = LAST - j;
        logic [63:0]   rem_in;
        logic [31:0]   root_in;
        vau_pkg::ctx_t ctx_i;
        logic [65:0]   trial;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in  = n_in;
            assign root_in = '0;
            assign ctx_i   = ctx_in;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign ctx_i   = ctx_reg[j-1];
        end

        assign trial = ({34'd0, root_in} << (K + 1)) + (66'd1 << (2 * K));
        assign take  = {2'b00, rem_in} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[j] <= take ? (root_in | (32'd1 << K)) : root_in;
                ctx_reg[j]  <= ctx_i;
            end
        end

        if (j < LAST) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? (rem_in - trial[63:0]) : rem_in;
                end
            end
        end
    end

    assign ctx_out  = ctx_reg[LAST];
    assign root_out = root_reg[LAST];

endmodule

[src/vau_div.sv]
module vau_div (
    input  logic          aclk,
    input  logic          en,
    input  vau_pkg::fix_t x,
    input  logic [32:0]   d_mag,
    input  logic          d_neg,
    output vau_pkg::fix_t q_out,
    output logic          sat_out
);

    localparam int NB   = vau_pkg::DIV_BITS;
    localparam int LAST = NB - 1;

    logic [NB-1:0] q_reg   [NB];
    logic          neg_reg [NB];
    logic [NB-1:0] dvd_reg [LAST];
    logic [32:0]   d_reg   [LAST];
    logic [32:0]   rem_reg [LAST];
    logic [31:0]   x_mag;
    logic [NB-1:0] q_fin;

    assign x_mag = x[31] ? 32'(-x) : 32'(x);

    // Restoring division, one quotient bit per stage.
    for (genvar j = 0; j < NB; j++) begin : g_step
        localparam int K = LAST - j;
        logic [NB-1:0] dvd_in, q_in;
        logic [32:0]   d_in, rem_in;
        logic          neg_in;
        logic [33:0]   shifted;
        logic          take;

        if (j == 0) begin : g_first
            assign dvd_in = {x_mag, vau_pkg::FRAC_BITS'(0)};
            assign d_in   = d_mag;
            assign rem_in = '0;
            assign q_in   = '0;
            assign neg_in = x[31] ^ d_neg;
        end else begin : g_next
            assign dvd_in = dvd_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign neg_in = neg_reg[j-1];
        end

        assign shifted = {rem_in, dvd_in[K]};
        assign take    = shifted >= {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j]   <= take ? (q_in | (vau_pkg::DQ_ONE << K)) : q_in;
                neg_reg[j] <= neg_in;
            end
        end

        if (j < LAST) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    dvd_reg[j] <= dvd_in;
                    d_reg[j]   <= d_in;
                    rem_reg[j] <= take ? 33'(shifted - {1'b0, d_in}) : shifted[32:0];
                end
            end
        end
    end

    // Apply the sign and clip to 32 bits.
    assign q_fin = q_reg[LAST];
    always_comb begin
        if (neg_reg[LAST]) begin
            sat_out = q_fin > {{(NB-32){1'b0}}, 32'h8000_0000};
            q_out   = sat_out ? 32'sh8000_0000 : vau_pkg::fix_t'(-q_fin[31:0]);
        end else begin
            sat_out = q_fin > {{(NB-32){1'b0}}, 32'h7fff_ffff};
            q_out   = sat_out ? 32'sh7fff_ffff : vau_pkg::fix_t'(q_fin[31:0]);
        end
    end

endmodule

[src/vector3_arithmetic_unit.sv]
// Pipeline: 85 register stages (input register, two lane stages, merge, 32 root stages,
// 48 divide stages, output); each result is offered from the output register.
// Throughput: one item per cycle; every operation flows through the same pipeline,
// which advances whenever the output register is empty or being taken.
// Reset: synchronous active-low aresetn clears all valid bits; data registers are not reset.
module vector3_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // ax, ay, az, bx, by, bz, scalar
    input  logic [3:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_x, result_y, result_z, result_scalar
    output logic [1:0]   m_tuser    // is_equal, saturated
);

    localparam int NB = vau_pkg::DIV_BITS;

    logic en;
    logic vld_reg [vau_pkg::PIPE_DEPTH];
    logic out_valid_reg;

    vau_pkg::ctx_t in_ctx_reg, ctx_a_reg, ctx_b_reg, mrg_ctx, sq_ctx, post;
    vau_pkg::ctx_t dl_reg [NB];
    vau_pkg::ctx_t fin, out_reg;
    vau_pkg::fix_t b_reg [3];
    vau_pkg::lane_res_t lanes [3];
    logic [63:0]   sumsq;
    logic [31:0]   root;
    logic [32:0]   d_mag;
    logic          d_neg;
    vau_pkg::fix_t q [3];
    logic          q_sat [3];

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vau_pkg::PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < vau_pkg::PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[vau_pkg::PIPE_DEPTH-1];
        end
    end

    // Input register and context for the lane stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            in_ctx_reg.cmd <= s_tuser;
            in_ctx_reg.a   <= s_tdata[95:0];
            in_ctx_reg.s   <= s_tdata[223:192];
            in_ctx_reg.v   <= '0;
            in_ctx_reg.sc  <= '0;
            in_ctx_reg.sat <= 1'b0;
            in_ctx_reg.eq  <= (s_tdata[95:0] == s_tdata[191:96]);
            b_reg[0] <= s_tdata[127:96];
            b_reg[1] <= s_tdata[159:128];
            b_reg[2] <= s_tdata[191:160];
            ctx_a_reg <= in_ctx_reg;
            ctx_b_reg <= ctx_a_reg;
        end
    end

    // One lane per component.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        vau_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .cmd  (in_ctx_reg.cmd),
            .ai   (in_ctx_reg.a[i]),
            .bi   (b_reg[i]),
            .s    (in_ctx_reg.s),
            .aj   (in_ctx_reg.a[(i+1)%3]),
            .bk   (b_reg[(i+2)%3]),
            .ak   (in_ctx_reg.a[(i+2)%3]),
            .bj   (b_reg[(i+1)%3]),
            .res  (lanes[i])
        );
    end

    vau_merge u_merge (
        .aclk      (aclk),
        .en        (en),
        .ctx_in    (ctx_b_reg),
        .lanes     (lanes),
        .ctx_out   (mrg_ctx),
        .sumsq_out (sumsq)
    );

    vau_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .ctx_in   (mrg_ctx),
        .n_in     (sumsq),
        .ctx_out  (sq_ctx),
        .root_out (root)
    );

    // Scalar results of the root and the divisor for the divide stages.
    always_comb begin
        post  = sq_ctx;
        d_mag = vau_pkg::FIX_ONE;
        d_neg = 1'b0;
        unique case (sq_ctx.cmd)
            vau_pkg::CMD_LENGTH, vau_pkg::CMD_DIST: begin
                post.sc  = root[31] ? 32'sh7fff_ffff : vau_pkg::fix_t'(root);
                post.sat = sq_ctx.sat | root[31];
            end
            vau_pkg::CMD_DIVIDE: begin
                if (sq_ctx.s != 32'sd0) begin
                    d_mag = {1'b0, sq_ctx.s[31] ? 32'(-sq_ctx.s) : 32'(sq_ctx.s)};
                    d_neg = sq_ctx.s[31];
                end
            end
            vau_pkg::CMD_NORM: begin
                if (root != 32'd0) begin
                    d_mag = {1'b0, root};
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        vau_div u_div (
            .aclk    (aclk),
            .en      (en),
            .x       (post.a[i]),
            .d_mag   (d_mag),
            .d_neg   (d_neg),
            .q_out   (q[i]),
            .sat_out (q_sat[i])
        );
    end

    // Context delay matched to the divider depth.
    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= post;
            for (int i = 1; i < NB; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    // Pick up the quotients for divide and normalize.
    always_comb begin
        fin = dl_reg[NB-1];
        if (fin.cmd == vau_pkg::CMD_DIVIDE || fin.cmd == vau_pkg::CMD_NORM) begin
            for (int i = 0; i < 3; i++) begin
                fin.v[i] = q[i];
                fin.sat  = fin.sat | q_sat[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.sc, out_reg.v[2], out_reg.v[1], out_reg.v[0]};
    assign m_tuser  = {out_reg.sat, out_reg.eq};

endmodule

[src/vau_checker.sv]
module vau_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The input side is open exactly when the output register can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (.*);
